[hw/rtl/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge including reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
package rau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    localparam int unsigned WORD_BITS = 64;

    typedef logic [WORD_BITS-1:0] t_word;

endpackage

[hw/rtl/rational_arithmetic_unit.sv]
// rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and gives the result reduced to lowest terms, with its mixed-number
// split. a transaction is taken when start is high and busy is low. busy stays
// high while the transaction is worked on and drops as the result appears. the
// result appears for exactly one cycle with o_done high and cannot be stalled,
// so the receiver must capture it in that cycle. the block has no configuration
// and no state between transactions. after the accepting edge it forms two
// products on the shared 32x32 multiplier, a third for add and subtract; then
// a combine step and a gcd load step; then a binary gcd that removes at least
// one bit a cycle; then a restoring division of 64 single-bit steps for each
// of the two divides by the gcd and the final divide for the whole part, all
// on one shared subtract-and-shift datapath; then the output state. a zero
// result gives the gcd equal operands of one and still runs the three divides.
// division by zero goes from the accepting state straight to the output state.
module rational_arithmetic_unit #(
    parameter int unsigned OPERAND_BITS = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      o_done,
    input  logic [1:0]                i_command,
    input  logic                      i_neg_a,
    input  logic [30:0]               i_num_a,
    input  logic [30:0]               i_den_a,
    input  logic                      i_neg_b,
    input  logic [30:0]               i_num_b,
    input  logic [30:0]               i_den_b,
    output logic                      o_infinite,
    output logic                      o_negative,
    output logic [62:0]               o_res_num,
    output logic [62:0]               o_res_den,
    output logic [62:0]               o_whole_part,
    output logic [61:0]               o_frac_num
);
    import rau_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_GFIX,
        S_DIVN, S_DIVD, S_DIVW, S_OUT
    } t_state;

    localparam int unsigned OB = OPERAND_BITS;
    localparam logic [30:0] OMASK = 31'((64'd1 << OB) - 64'd1);

    t_state       r_state;
    t_cmd         r_cmd;
    logic         r_sa, r_sq;
    logic [30:0]  r_na, r_da, r_nb, r_db;
    t_word        r_p, r_q;           // products / gcd operands
    t_word        r_mag, r_den;
    logic         r_neg;
    logic [6:0]   r_k;                // common power of two in the gcd
    logic [6:0]   r_cnt;              // division step count
    t_word        r_quo, r_rem;       // restoring division registers
    t_word        r_g;

    // shared 32x32 multiplier with operand select
    logic [31:0]  mul_x, mul_y;
    t_word        mul_out;
    // shared subtract stage
    t_word        sub_x, sub_y;
    logic [64:0]  sub_d;
    // one restoring division step
    t_word        div_div;
    logic [64:0]  div_trial;
    t_word        div_rem_sh;

    logic [30:0]  in_da, in_db;

    always_comb begin
        unique case (r_state)
            S_MUL1:  begin mul_x = {1'b0, r_na}; mul_y = (r_cmd == CMD_MUL) ? {1'b0, r_nb} : {1'b0, r_db}; end
            S_MUL2:  begin mul_x = {1'b0, r_da}; mul_y = (r_cmd == CMD_DIV) ? {1'b0, r_nb} : {1'b0, r_db}; end
            default: begin mul_x = {1'b0, r_nb}; mul_y = {1'b0, r_da}; end
        endcase
        mul_out = t_word'(mul_x) * t_word'(mul_y);
    end

    always_comb begin
        sub_x = r_p;
        sub_y = r_q;
        if (r_state == S_COMB) begin
            sub_x = (r_p >= r_q) ? r_p : r_q;
            sub_y = (r_p >= r_q) ? r_q : r_p;
        end else if (r_state == S_GCD && r_p < r_q) begin
            sub_x = r_q;
            sub_y = r_p;
        end
        sub_d = {1'b0, sub_x} - {1'b0, sub_y};
    end

    always_comb begin
        div_div    = (r_state == S_DIVW) ? r_den : r_g;
        div_rem_sh = {r_rem[62:0], r_quo[63]};
        div_trial  = {r_rem, r_quo[63]} - {1'b0, div_div};
    end

    assign in_da = ((i_den_a & OMASK) == '0) ? 31'd1 : (i_den_a & OMASK);
    assign in_db = ((i_den_b & OMASK) == '0) ? 31'd1 : (i_den_b & OMASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            busy    <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            // result strobe, registered from the output state
            o_done <= (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= t_cmd'(i_command);
                        r_sa  <= i_neg_a;
                        r_sq  <= (t_cmd'(i_command) == CMD_SUB) ? !i_neg_b : i_neg_b;
                        r_na  <= i_num_a & OMASK;
                        r_nb  <= i_num_b & OMASK;
                        r_da  <= in_da;
                        r_db  <= in_db;
                        busy  <= 1'b1;
                        if (t_cmd'(i_command) == CMD_DIV && (i_num_b & OMASK) == '0) begin
                            o_infinite   <= 1'b1;
                            o_negative   <= 1'b0;
                            o_res_num    <= '0;
                            o_res_den    <= '0;
                            o_whole_part <= '0;
                            o_frac_num   <= '0;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_p     <= mul_out;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_den <= mul_out;
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_state <= S_MUL3;
                    end else begin
                        r_mag   <= r_p;
                        r_neg   <= r_sa ^ r_sq ^ (r_cmd == CMD_SUB);
                        r_q     <= '0;
                        r_state <= S_COMB;
                    end
                end
                S_MUL3: begin
                    // cross product of b with the denominator of a
                    r_q     <= mul_out;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        if (r_sa == r_sq) begin
                            r_mag <= r_p + r_q;
                            r_neg <= r_sa;
                        end else begin
                            r_mag <= sub_d[63:0];
                            r_neg <= (r_p >= r_q) ? r_sa : r_sq;
                        end
                    end
                    r_state <= S_GFIX;
                    r_k     <= '0;
                end
                S_GFIX: begin
                    // load gcd operands, set to one for a zero result
                    if (r_mag == '0) begin
                        r_neg   <= 1'b0;
                        r_den   <= 64'd1;
                        r_g     <= 64'd1;
                        r_p     <= 64'd1;
                        r_q     <= 64'd1;
                        r_state <= S_GCD;
                    end else begin
                        r_p     <= r_mag;
                        r_q     <= r_den;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // binary gcd, one step a cycle
                    if (r_p == r_q) begin
                        r_g     <= r_p << r_k;
                        r_quo   <= r_mag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_p[0] && !r_q[0]) begin
                        r_p <= r_p >> 1;
                        r_q <= r_q >> 1;
                        r_k <= r_k + 7'd1;
                    end else if (!r_p[0]) begin
                        r_p <= r_p >> 1;
                    end else if (!r_q[0]) begin
                        r_q <= r_q >> 1;
                    end else if (r_p > r_q) begin
                        r_p <= sub_d[63:0] >> 1;
                    end else begin
                        r_q <= sub_d[63:0] >> 1;
                    end
                end
                S_DIVN, S_DIVD, S_DIVW: begin
                    if (r_cnt != 7'd63) begin
                        r_rem <= div_trial[64] ? div_rem_sh : div_trial[63:0];
                        r_quo <= {r_quo[62:0], !div_trial[64]};
                        r_cnt <= r_cnt + 7'd1;
                    end else begin
                        // last step: hand the quotient on and set up the next divide, or write the outputs
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (r_state == S_DIVN) begin
                            r_mag   <= {r_quo[62:0], !div_trial[64]};
                            r_quo   <= r_den;
                            r_state <= S_DIVD;
                        end else if (r_state == S_DIVD) begin
                            r_den   <= {r_quo[62:0], !div_trial[64]};
                            r_quo   <= r_mag;
                            r_state <= S_DIVW;
                        end else begin
                            o_infinite   <= 1'b0;
                            o_negative   <= r_neg;
                            o_res_num    <= r_mag[62:0];
                            o_res_den    <= r_den[62:0];
                            o_whole_part <= {r_quo[61:0], !div_trial[64]};
                            o_frac_num   <= !div_trial[64] ? div_trial[61:0] : div_rem_sh[61:0];
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    busy    <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_done_ends_busy, i_clk, i_rst_n, o_done |-> !busy, "done while still busy")
    `ASSERT_CLK(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "done held over two cycles")
    `ASSERT_CLK(a_inf_clean, i_clk, i_rst_n, (o_done && o_infinite) |-> (o_res_num == '0 && o_res_den == '0), "infinite result with nonzero fields")
    `ASSERT_CLK(a_den_nonzero, i_clk, i_rst_n, (o_done && !o_infinite) |-> (o_res_den != '0), "zero denominator on finite result")

endmodule
